// ----- hw/rtl/usv_pkg.sv -----
`default_nettype none
package usv_pkg;

   // Position counter widths and the width they are shown at on the result
   localparam int LINE_BITS    = 24;
   localparam int COLUMN_BITS  = 24;
   localparam int POS_OUT_BITS = 24;

   localparam int CP_BITS    = 21;
   localparam int WIDTH_BITS = 3;

   // Result queue depth ahead of the output register
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Byte classes
   localparam logic [7:0] BYTE_ASCII_END = 8'h80;
   localparam logic [7:0] LEAD2_LO       = 8'hc2;
   localparam logic [7:0] LEAD2_HI       = 8'hdf;
   localparam logic [7:0] LEAD3_HI       = 8'hef;
   localparam logic [7:0] LEAD4_HI       = 8'hf4;
   localparam logic [7:0] BYTE_NEWLINE   = 8'h0a;
   localparam logic [1:0] CONT_TAG       = 2'b10;

   // Code point limits
   localparam logic [CP_BITS-1:0] CP_MAX       = 21'h10ffff;
   localparam logic [CP_BITS-1:0] SURR_LO      = 21'h00d800;
   localparam logic [CP_BITS-1:0] SURR_HI      = 21'h00dfff;
   localparam logic [CP_BITS-1:0] MIN_WIDTH2   = 21'h000080;
   localparam logic [CP_BITS-1:0] MIN_WIDTH3   = 21'h000800;
   localparam logic [CP_BITS-1:0] MIN_WIDTH4   = 21'h010000;

   localparam logic [WIDTH_BITS-1:0] WIDTH_NONE  = 3'd0;
   localparam logic [WIDTH_BITS-1:0] WIDTH_ONE   = 3'd1;
   localparam logic [WIDTH_BITS-1:0] WIDTH_TWO   = 3'd2;
   localparam logic [WIDTH_BITS-1:0] WIDTH_THREE = 3'd3;
   localparam logic [WIDTH_BITS-1:0] WIDTH_FOUR  = 3'd4;

   localparam logic [LINE_BITS-1:0]   LINE_ONE   = {{(LINE_BITS-1){1'b0}}, 1'b1};
   localparam logic [COLUMN_BITS-1:0] COLUMN_ONE = {{(COLUMN_BITS-1){1'b0}}, 1'b1};

   typedef struct packed {
      logic [CP_BITS-1:0]      char_value;
      logic [WIDTH_BITS-1:0]   char_bytes;
      logic [POS_OUT_BITS-1:0] start_line;
      logic [POS_OUT_BITS-1:0] start_column;
      logic                    is_error;
      logic                    is_final;
   } usv_result_type;

   typedef struct packed {
      logic           valid;
      usv_result_type result;
   } usv_push_type;

   // Smallest legal value for a sequence of the given width
   function automatic logic [CP_BITS-1:0] width_minimum(input logic [WIDTH_BITS-1:0] w);
      logic [CP_BITS-1:0] m;
      case (w)
         WIDTH_TWO:   m = MIN_WIDTH2;
         WIDTH_THREE: m = MIN_WIDTH3;
         default:     m = MIN_WIDTH4;
      endcase
      return m;
   endfunction

   // Cap a line count at the shown width
   function automatic logic [POS_OUT_BITS-1:0] cap_line(input logic [LINE_BITS-1:0] v);
      logic [LINE_BITS+POS_OUT_BITS-1:0] wide;
      logic [POS_OUT_BITS-1:0]           r;
      wide = {{POS_OUT_BITS{1'b0}}, v};
      if (wide > {{LINE_BITS{1'b0}}, {POS_OUT_BITS{1'b1}}}) begin
         r = '1;
      end else begin
         r = wide[POS_OUT_BITS-1:0];
      end
      return r;
   endfunction

   // Cap a column count at the shown width
   function automatic logic [POS_OUT_BITS-1:0] cap_column(input logic [COLUMN_BITS-1:0] v);
      logic [COLUMN_BITS+POS_OUT_BITS-1:0] wide;
      logic [POS_OUT_BITS-1:0]             r;
      wide = {{POS_OUT_BITS{1'b0}}, v};
      if (wide > {{COLUMN_BITS{1'b0}}, {POS_OUT_BITS{1'b1}}}) begin
         r = '1;
      end else begin
         r = wide[POS_OUT_BITS-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/usv_front.sv -----
`default_nettype none
module usv_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_last_byte,
   output usv_pkg::usv_push_type     push
);
   import usv_pkg::*;

   logic [1:0]             rem_ff, rem_in;
   logic [CP_BITS-1:0]     acc_ff, acc_in;
   logic [WIDTH_BITS-1:0]  width_ff, width_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [LINE_BITS-1:0]   seq_line_ff, seq_line_in;
   logic [COLUMN_BITS-1:0] seq_col_ff, seq_col_in;
   logic                   failed_ff, failed_in;

   logic                   accept;
   logic                   emit;
   logic                   err;
   logic [CP_BITS-1:0]     cp;
   logic [WIDTH_BITS-1:0]  nb;
   logic [LINE_BITS-1:0]   ln;
   logic [COLUMN_BITS-1:0] cl;
   logic [CP_BITS-1:0]     acc_next;
   logic [WIDTH_BITS-1:0]  lead_width;

   assign accept   = req_valid && !req_stall;
   assign acc_next = {acc_ff[CP_BITS-7:0], req_data_byte[5:0]};

   // Classify the byte and advance the decode state
   always_comb begin
      rem_in      = rem_ff;
      acc_in      = acc_ff;
      width_in    = width_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      seq_line_in = seq_line_ff;
      seq_col_in  = seq_col_ff;
      failed_in   = failed_ff;
      emit        = 1'b0;
      err         = 1'b0;
      cp          = '0;
      nb          = WIDTH_NONE;
      ln          = line_ff;
      cl          = col_ff;
      lead_width  = WIDTH_FOUR;

      if (accept && !failed_ff) begin
         if (rem_ff == 2'd0) begin
            if (req_data_byte < BYTE_ASCII_END) begin
               emit = 1'b1;
               cp   = {{(CP_BITS-8){1'b0}}, req_data_byte};
               nb   = WIDTH_ONE;
            end else if (req_data_byte >= LEAD2_LO && req_data_byte <= LEAD4_HI) begin
               // open a multi-byte sequence
               if (req_data_byte <= LEAD2_HI) begin
                  lead_width = WIDTH_TWO;
                  acc_in     = {{(CP_BITS-5){1'b0}}, req_data_byte[4:0]};
               end else if (req_data_byte <= LEAD3_HI) begin
                  lead_width = WIDTH_THREE;
                  acc_in     = {{(CP_BITS-4){1'b0}}, req_data_byte[3:0]};
               end else begin
                  lead_width = WIDTH_FOUR;
                  acc_in     = {{(CP_BITS-3){1'b0}}, req_data_byte[2:0]};
               end
               width_in    = lead_width;
               rem_in      = 2'(lead_width - WIDTH_ONE);
               seq_line_in = line_ff;
               seq_col_in  = col_ff;
               if (req_last_byte) begin
                  emit = 1'b1;
                  err  = 1'b1;
               end
            end else begin
               emit = 1'b1;
               err  = 1'b1;
            end
         end else begin
            ln = seq_line_ff;
            cl = seq_col_ff;
            if (req_data_byte[7:6] != CONT_TAG) begin
               emit = 1'b1;
               err  = 1'b1;
            end else begin
               acc_in = acc_next;
               rem_in = rem_ff - 2'd1;
               if (rem_ff == 2'd1) begin
                  // sequence complete: check range
                  emit = 1'b1;
                  if (acc_next < width_minimum(width_ff) || acc_next > CP_MAX ||
                      (acc_next >= SURR_LO && acc_next <= SURR_HI)) begin
                     err = 1'b1;
                  end else begin
                     cp = acc_next;
                     nb = width_ff;
                  end
               end else if (req_last_byte) begin
                  emit = 1'b1;
                  err  = 1'b1;
               end
            end
         end

         // advance the position
         if (req_data_byte == BYTE_NEWLINE) begin
            line_in = (line_ff == '1) ? line_ff : line_ff + LINE_ONE;
            col_in  = COLUMN_ONE;
         end else begin
            col_in = (col_ff == '1) ? col_ff : col_ff + COLUMN_ONE;
         end

         // latch the failure and drop the open sequence
         if (emit && err) begin
            failed_in = 1'b1;
            rem_in    = 2'd0;
            acc_in    = '0;
            width_in  = WIDTH_NONE;
         end
      end

      // end of stream: return to reset values
      if (accept && req_last_byte) begin
         rem_in      = 2'd0;
         acc_in      = '0;
         width_in    = WIDTH_NONE;
         line_in     = LINE_ONE;
         col_in      = COLUMN_ONE;
         seq_line_in = LINE_ONE;
         seq_col_in  = COLUMN_ONE;
         failed_in   = 1'b0;
      end
   end

   // Build the result item for the queue
   always_comb begin
      push.valid               = emit;
      push.result.char_value   = err ? '0 : cp;
      push.result.char_bytes   = err ? WIDTH_NONE : nb;
      push.result.start_line   = cap_line(ln);
      push.result.start_column = cap_column(cl);
      push.result.is_error     = err;
      push.result.is_final     = err || req_last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff      <= 2'd0;
         acc_ff      <= '0;
         width_ff    <= WIDTH_NONE;
         line_ff     <= LINE_ONE;
         col_ff      <= COLUMN_ONE;
         seq_line_ff <= LINE_ONE;
         seq_col_ff  <= COLUMN_ONE;
         failed_ff   <= 1'b0;
      end else begin
         rem_ff      <= rem_in;
         acc_ff      <= acc_in;
         width_ff    <= width_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
         seq_line_ff <= seq_line_in;
         seq_col_ff  <= seq_col_in;
         failed_ff   <= failed_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/usv_queue.sv -----
`default_nettype none
module usv_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire usv_pkg::usv_push_type  push,
   output logic                        full,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output usv_pkg::usv_result_type     rsp_result
);
   import usv_pkg::*;

   usv_result_type           mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QCNT_BITS-1:0]     count_ff, count_in;
   logic                     out_valid_ff, out_valid_in;
   usv_result_type           out_data_ff;

   logic load;
   logic from_mem;
   logic bypass;
   logic to_mem;

   assign full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_data_ff;

   // Refill the output register from the queue, or straight from the front when empty
   assign load     = !out_valid_ff || !rsp_stall;
   assign from_mem = load && (count_ff != '0);
   assign bypass   = load && (count_ff == '0) && push.valid;
   assign to_mem   = push.valid && !bypass;

   always_comb begin
      rd_ptr_in    = from_mem ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      wr_ptr_in    = to_mem ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      count_in     = count_ff + QCNT_BITS'(to_mem) - QCNT_BITS'(from_mem);
      out_valid_in = load ? (from_mem || bypass) : out_valid_ff;
   end

   // Write the queue storage
   always_ff @(posedge clock) begin
      if (to_mem) begin
         mem[wr_ptr_ff] <= push.result;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (from_mem) begin
         out_data_ff <= mem[rd_ptr_ff];
      end else if (bypass) begin
         out_data_ff <= push.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/utf8_stream_validator.sv -----
`default_nettype none
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_stall  | data_byte, last_byte
// rsp     | out       | rsp_valid / rsp_stall  | code point, char_bytes, start_line,
//         |           |                        | start_column, is_error, is_final
//
// One byte is taken every cycle while req_stall is low; the decode state updates in the cycle the byte is taken.
// A result reaches rsp through the output register, straight from the front when the queue is empty.
// A four-entry queue plus the output register absorbs results while rsp is stalled;
// req_stall rises only when that queue is full.
// Synchronous reset clears decode state, positions and the queue.
module utf8_stream_validator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_data_byte,
   input  wire logic                              req_last_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [usv_pkg::CP_BITS-1:0]            rsp_code_point,
   output logic [usv_pkg::WIDTH_BITS-1:0]         rsp_char_bytes,
   output logic [usv_pkg::POS_OUT_BITS-1:0]       rsp_start_line,
   output logic [usv_pkg::POS_OUT_BITS-1:0]       rsp_start_column,
   output logic                                   rsp_is_error,
   output logic                                   rsp_is_final
);
   import usv_pkg::*;

   usv_push_type   push;
   usv_result_type result;
   logic           full;

   usv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .push          (push)
   );

   usv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (result)
   );

   assign req_stall        = full;
   assign rsp_code_point   = result.char_value;
   assign rsp_char_bytes   = result.char_bytes;
   assign rsp_start_line   = result.start_line;
   assign rsp_start_column = result.start_column;
   assign rsp_is_error     = result.is_error;
   assign rsp_is_final     = result.is_final;

   // An error result is final and carries no character
   a_error_final : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_error) |->
         (rsp_is_final && rsp_code_point == '0 && rsp_char_bytes == WIDTH_NONE))
      else $error("error result not final or carries a character");

   // A good result has a width of one to four and a legal code point
   a_good_char : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_error) |->
         ((rsp_char_bytes == WIDTH_ONE || rsp_char_bytes == WIDTH_TWO ||
           rsp_char_bytes == WIDTH_THREE || rsp_char_bytes == WIDTH_FOUR) &&
          rsp_code_point <= CP_MAX &&
          !(rsp_code_point >= SURR_LO && rsp_code_point <= SURR_HI)))
      else $error("good result with bad width or code point");

   // Input stalls only while results are backed up behind the output register
   a_stall_backed : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // Reset empties the queue
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("queue not empty after reset");

endmodule
`default_nettype wire

// ----- tb/sv/tb_utf8_stream_validator.sv -----
`timescale 1ns / 1ps

module tb_utf8_stream_validator;
   import usv_pkg::*;

   localparam int RANDOM_BYTES = 1900;
   localparam int QUIET_LIMIT  = 1000;
   localparam int TAIL_CYCLES  = 8;

   typedef enum int {
      FAULT_BAD_LEAD,
      FAULT_BAD_CONT,
      FAULT_OVERLONG,
      FAULT_SURROGATE,
      FAULT_TOO_HIGH,
      FAULT_TRUNCATED
   } fault_kind_type;

   // Decoder copy plus the chars it still owes on rsp
   class utf8_char_tracker_type;
      logic [1:0]             cont_left;
      logic [CP_BITS-1:0]     partial_cp;
      logic [WIDTH_BITS-1:0]  seq_width;
      logic [LINE_BITS-1:0]   cur_line;
      logic [COLUMN_BITS-1:0] cur_column;
      logic [LINE_BITS-1:0]   seq_line;
      logic [COLUMN_BITS-1:0] seq_column;
      bit                     stream_failed;
      usv_result_type         chars_due[$];
      int unsigned            mismatches = 0;
      int unsigned            bytes_decoded = 0;

      function void restart();
         cont_left     = 2'd0;
         partial_cp    = '0;
         seq_width     = WIDTH_NONE;
         cur_line      = LINE_ONE;
         cur_column    = COLUMN_ONE;
         seq_line      = LINE_ONE;
         seq_column    = COLUMN_ONE;
         stream_failed = 1'b0;
      endfunction

      function void take_byte(logic [7:0] b, bit last);
         usv_result_type         r;
         bit                     emit;
         bit                     err;
         logic [CP_BITS-1:0]     cp;
         logic [CP_BITS-1:0]     floor_cp;
         logic [WIDTH_BITS-1:0]  nb;
         logic [LINE_BITS-1:0]   ln;
         logic [COLUMN_BITS-1:0] col;
         emit = 1'b0;
         err  = 1'b0;
         cp   = '0;
         nb   = WIDTH_NONE;
         ln   = cur_line;
         col  = cur_column;

         // Drop everything after an error until the stream ends
         if (stream_failed) begin
            if (last) restart();
            return;
         end
         bytes_decoded++;

         if (cont_left == 2'd0) begin
            // Outside a sequence: ASCII, a lead byte, or a bad lead
            if (b < BYTE_ASCII_END) begin
               emit = 1'b1;
               cp   = CP_BITS'(b);
               nb   = WIDTH_ONE;
            end else if (b >= LEAD2_LO && b <= LEAD4_HI) begin
               if (b <= LEAD2_HI) begin
                  seq_width  = WIDTH_TWO;
                  partial_cp = CP_BITS'(b & 8'h1f);
               end else if (b <= LEAD3_HI) begin
                  seq_width  = WIDTH_THREE;
                  partial_cp = CP_BITS'(b & 8'h0f);
               end else begin
                  seq_width  = WIDTH_FOUR;
                  partial_cp = CP_BITS'(b & 8'h07);
               end
               cont_left  = 2'(seq_width - 1);
               seq_line   = cur_line;
               seq_column = cur_column;
               if (last) begin
                  emit = 1'b1;
                  err  = 1'b1;
               end
            end else begin
               emit = 1'b1;
               err  = 1'b1;
            end
         end else begin
            // Inside a sequence: report at its start
            ln  = seq_line;
            col = seq_column;
            if (b[7:6] != CONT_TAG) begin
               emit = 1'b1;
               err  = 1'b1;
            end else begin
               partial_cp = {partial_cp[CP_BITS-7:0], b[5:0]};
               cont_left  = cont_left - 2'd1;
               if (cont_left == 2'd0) begin
                  floor_cp = (seq_width == WIDTH_TWO)   ? MIN_WIDTH2 :
                             (seq_width == WIDTH_THREE) ? MIN_WIDTH3 : MIN_WIDTH4;
                  emit = 1'b1;
                  if (partial_cp < floor_cp || partial_cp > CP_MAX ||
                      (partial_cp >= SURR_LO && partial_cp <= SURR_HI)) begin
                     err = 1'b1;
                  end else begin
                     cp = partial_cp;
                     nb = seq_width;
                  end
               end else if (last) begin
                  emit = 1'b1;
                  err  = 1'b1;
               end
            end
         end

         // Advance the position, saturating
         if (b == BYTE_NEWLINE) begin
            if (cur_line != '1) cur_line++;
            cur_column = COLUMN_ONE;
         end else if (cur_column != '1) begin
            cur_column++;
         end

         if (emit) begin
            r.char_value   = err ? '0 : cp;
            r.char_bytes   = err ? WIDTH_NONE : nb;
            r.start_line   = cap_line(ln);
            r.start_column = cap_column(col);
            r.is_error     = err;
            r.is_final     = err || last;
            chars_due.insert(chars_due.size(), r);
            if (err) begin
               stream_failed = 1'b1;
               cont_left     = 2'd0;
               partial_cp    = '0;
               seq_width     = WIDTH_NONE;
            end
         end

         if (last) restart();
      endfunction

      function void check_char(usv_result_type got);
         usv_result_type want;
         if (chars_due.size() == 0) begin
            $error("unexpected char: rsp_code_point expected none got %h is_error %b",
                   got.char_value, got.is_error);
            mismatches++;
            return;
         end
         want = chars_due.pop_front();
         if (got.char_value !== want.char_value) begin
            $error("rsp_code_point expected %h got %h", want.char_value, got.char_value);
            mismatches++;
         end
         if (got.char_bytes !== want.char_bytes) begin
            $error("char_bytes expected %0d got %0d", want.char_bytes, got.char_bytes);
            mismatches++;
         end
         if (got.start_line !== want.start_line) begin
            $error("start_line expected %0d got %0d", want.start_line, got.start_line);
            mismatches++;
         end
         if (got.start_column !== want.start_column) begin
            $error("start_column expected %0d got %0d", want.start_column, got.start_column);
            mismatches++;
         end
         if (got.is_error !== want.is_error) begin
            $error("is_error expected %b got %b", want.is_error, got.is_error);
            mismatches++;
         end
         if (got.is_final !== want.is_final) begin
            $error("is_final expected %b got %b", want.is_final, got.is_final);
            mismatches++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [7:0]              req_data_byte;
   logic                    req_last_byte;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [CP_BITS-1:0]      rsp_code_point;
   logic [WIDTH_BITS-1:0]   rsp_char_bytes;
   logic [POS_OUT_BITS-1:0] rsp_start_line;
   logic [POS_OUT_BITS-1:0] rsp_start_column;
   logic                    rsp_is_error;
   logic                    rsp_is_final;

   utf8_char_tracker_type tracker;
   logic [7:0]            text_bytes[$];
   int unsigned           req_gap_pct = 0;
   int unsigned           rsp_hold_pct = 0;
   int unsigned           quiet_cycles = 0;

   utf8_stream_validator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_point   (rsp_code_point),
      .rsp_char_bytes   (rsp_char_bytes),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_column (rsp_start_column),
      .rsp_is_error     (rsp_is_error),
      .rsp_is_final     (rsp_is_final)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hand one byte over, with an occasional gap ahead of it
   task automatic send_byte(input logic [7:0] b, input bit last);
      @(negedge clock);
      if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      tracker.take_byte(b, last);
   endtask

   // Send the queued text as one stream, last flag on its final byte
   task automatic send_text();
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
      text_bytes.delete();
   endtask

   // Hold the sender until every owed char has come out
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.chars_due.size() != 0) @(posedge clock);
   endtask

   // Append one byte to the pending text
   function automatic void put_byte(logic [7:0] b);
      text_bytes.insert(text_bytes.size(), b);
   endfunction

   function automatic void put_code(int unsigned cp, logic [WIDTH_BITS-1:0] w);
      case (w)
         WIDTH_ONE: begin
            put_byte(8'(cp));
         end
         WIDTH_TWO: begin
            put_byte(8'hc0 | 8'(cp >> 6));
            put_byte(8'h80 | 8'(cp & 'h3f));
         end
         WIDTH_THREE: begin
            put_byte(8'he0 | 8'(cp >> 12));
            put_byte(8'h80 | 8'((cp >> 6) & 'h3f));
            put_byte(8'h80 | 8'(cp & 'h3f));
         end
         default: begin
            put_byte(8'hf0 | 8'(cp >> 18));
            put_byte(8'h80 | 8'((cp >> 12) & 'h3f));
            put_byte(8'h80 | 8'((cp >> 6) & 'h3f));
            put_byte(8'h80 | 8'(cp & 'h3f));
         end
      endcase
   endfunction

   function automatic logic [WIDTH_BITS-1:0] random_width(bit multi_only);
      int unsigned roll;
      roll = multi_only ? $urandom_range(9, 4) : $urandom_range(9);
      if (roll < 4) return WIDTH_ONE;
      if (roll < 6) return WIDTH_TWO;
      if (roll < 8) return WIDTH_THREE;
      return WIDTH_FOUR;
   endfunction

   // Legal scalar value that needs exactly the given width
   function automatic int unsigned random_scalar(logic [WIDTH_BITS-1:0] w);
      int unsigned cp;
      case (w)
         WIDTH_ONE:   cp = ($urandom_range(9) == 0) ? BYTE_NEWLINE : $urandom_range(8'h7f);
         WIDTH_TWO:   cp = $urandom_range(MIN_WIDTH2, MIN_WIDTH3 - 1);
         WIDTH_THREE: begin
            do cp = $urandom_range(MIN_WIDTH3, MIN_WIDTH4 - 1);
            while (cp >= SURR_LO && cp <= SURR_HI);
         end
         default:     cp = $urandom_range(MIN_WIDTH4, CP_MAX);
      endcase
      return cp;
   endfunction

   // Queue one broken sequence of the given kind
   function automatic void put_fault(fault_kind_type kind);
      logic [WIDTH_BITS-1:0] w;
      logic [7:0]            b;
      int unsigned           keep;
      w = random_width(1'b1);
      case (kind)
         FAULT_BAD_LEAD: begin
            b = $urandom_range(1) ? 8'($urandom_range(8'h80, 8'hc1)) :
                                    8'($urandom_range(8'hf5, 8'hff));
            put_byte(b);
         end
         FAULT_BAD_CONT, FAULT_TRUNCATED: begin
            // Keep the lead and possibly some continuations, then cut or corrupt
            put_code(random_scalar(w), w);
            keep = $urandom_range(1, w - 1);
            repeat (w - keep) text_bytes.delete(text_bytes.size() - 1);
            if (kind == FAULT_BAD_CONT) begin
               do b = 8'($urandom); while (b[7:6] == CONT_TAG);
               put_byte(b);
            end
         end
         FAULT_OVERLONG: begin
            case (w)
               WIDTH_TWO:   put_code($urandom_range(MIN_WIDTH2 - 1), w);
               WIDTH_THREE: put_code($urandom_range(MIN_WIDTH3 - 1), w);
               default:     put_code($urandom_range(MIN_WIDTH4 - 1), w);
            endcase
         end
         FAULT_SURROGATE: put_code($urandom_range(SURR_LO, SURR_HI), WIDTH_THREE);
         default:         put_code($urandom_range(CP_MAX + 1, 21'h1fffff), WIDTH_FOUR);
      endcase
   endfunction

   // One random stream: mostly clean text, some with a fault, some noise
   task automatic random_stream();
      int unsigned           nchars;
      int unsigned           fault_at;
      int unsigned           roll;
      fault_kind_type        kind;
      logic [WIDTH_BITS-1:0] w;
      nchars = ($urandom_range(7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      roll   = $urandom_range(99);
      if (roll < 8) begin
         repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
      end else begin
         fault_at = (roll < 35) ? $urandom_range(nchars - 1) : nchars;
         for (int i = 0; i < nchars; i++) begin
            if (i == fault_at) begin
               kind = fault_kind_type'($urandom_range(FAULT_TRUNCATED));
               put_fault(kind);
               if (kind != FAULT_TRUNCATED) begin
                  repeat ($urandom_range(4)) put_byte(8'($urandom));
               end
               break;
            end
            w = random_width(1'b0);
            put_code(random_scalar(w), w);
         end
      end
      send_text();
   endtask

   // Stall the result side in random bursts
   initial begin
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_hold_pct != 0 && $urandom_range(99) < rsp_hold_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check every char taken from rsp
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_char({rsp_code_point, rsp_char_bytes, rsp_start_line,
                             rsp_start_column, rsp_is_error, rsp_is_final});
      end
   end

   // End the run when neither side moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      req_last_byte = 1'b0;
      tracker = new();
      tracker.restart();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Clean stream across the one- and two-byte extremes, the lowest three-byte and the highest code point
      rsp_hold_pct = 20;
      text_bytes = '{8'h00, 8'h7f, BYTE_NEWLINE, 8'hc2, 8'h80, 8'hdf, 8'hbf,
                     8'he0, 8'ha0, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
      send_text();
      // Surrogate, then a dropped byte carrying the last flag
      text_bytes = '{8'hed, 8'ha0, 8'h80, 8'h41};
      send_text();
      // Value above the top of the range
      text_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80};
      send_text();
      // Overlong three-byte form
      text_bytes = '{8'he0, 8'h9f, 8'hbf};
      send_text();
      // Bad lead byte
      text_bytes = '{8'hff, 8'h20};
      send_text();
      // Bad continuation
      text_bytes = '{8'hc3, 8'h41};
      send_text();
      // Sequence cut off by the last byte
      text_bytes = '{8'he1, 8'h80};
      send_text();
      wait_drained();

      // Random streams; calm down both sides near the end
      tracker.bytes_decoded = 0;
      while (tracker.bytes_decoded < RANDOM_BYTES) begin
         if (tracker.bytes_decoded > RANDOM_BYTES * 85 / 100) begin
            req_gap_pct  = 0;
            rsp_hold_pct = 0;
         end else begin
            case ($urandom_range(3))
               0:       req_gap_pct = 0;
               1:       req_gap_pct = 5;
               2:       req_gap_pct = 20;
               default: req_gap_pct = 40;
            endcase
            case ($urandom_range(3))
               0:       rsp_hold_pct = 0;
               1:       rsp_hold_pct = 5;
               2:       rsp_hold_pct = 20;
               default: rsp_hold_pct = 50;
            endcase
         end
         random_stream();
         if ($urandom_range(39) == 0) wait_drained();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.chars_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/usv_pkg.sv
hw/rtl/usv_front.sv
hw/rtl/usv_queue.sv
hw/rtl/utf8_stream_validator.sv
tb/sv/tb_utf8_stream_validator.sv
